### sv/fcto_pkg.sv
package fcto_pkg;

    // default number of table entries
    localparam int TABLE_DEPTH_DEF = 16;

    // operation codes
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_REPORT = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // result action codes
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_ZERO    = 3'd1,
        ACT_DUP     = 3'd2,
        ACT_UPDATE  = 3'd3,
        ACT_APPEND  = 3'd4,
        ACT_REPLACE = 3'd5
    } act_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_READ
    } state_t;

    // one request transaction
    typedef struct packed {
        op_t         op;
        logic [23:0] dtc_code;
        logic [7:0]  dtc_status;
        logic [7:0]  entry_index;
    } req_t;

    // one result transaction
    typedef struct packed {
        act_t        action;
        logic [3:0]  slot;
        logic        entry_valid;
        logic [23:0] entry_code;
        logic [7:0]  entry_status;
        logic [31:0] entry_time;
        logic [4:0]  entry_count;
    } rsp_t;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [23:0] code;
        logic [7:0]  status;
        logic [31:0] tstamp;
    } entry_t;

endpackage

### sv/fault_code_table_oldest_replace_core.sv
// tick and clear give their result in the next cycle; a read goes through S_READ, a report
// through S_CHECK, ending there if ignored, suppressed or the table is empty, else on through
// S_SCAN, S_DRAIN and S_DECIDE; one transaction at a time, the next accepted in the cycle its
// result shows; a report scans the held entries through the single read port of the entry
// memory, one a cycle; reset clears count, tick counter, last pair and control; memory is never
// read unless written since; the receiver cannot stall, so each result shows for one cycle only
module fault_code_table_oldest_replace_core
    import fcto_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // entry memory
    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    logic [IDX_W-1:0] mem_raddr;
    logic [IDX_W-1:0] mem_waddr;
    entry_t mem_wdata;
    logic mem_we;

    state_t state_reg, state_next;
    req_t req_reg;
    logic rd_ok_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] tick_reg;
    logic [31:0] last_reg, last_next;
    logic [IDX_W-1:0] issue_reg;
    logic chk_vld_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic match_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [31:0] min_time_reg;
    logic [IDX_W-1:0] min_idx_reg;
    rsp_t rsp_reg, rsp_next;
    logic done_reg, done_next;

    logic accept;
    logic [31:0] pair;
    logic new_pair;
    logic issue_last;
    logic full;
    logic hit;

    assign accept     = start && (state_reg == S_IDLE);
    assign pair       = {req_reg.dtc_code, req_reg.dtc_status};
    assign new_pair   = (req_reg.dtc_code != 24'd0) && (pair != last_reg);
    assign issue_last = (CNT_W'(issue_reg) == (cnt_reg - CNT_W'(1)));
    assign full       = (cnt_reg == CNT_W'(TABLE_DEPTH));
    assign hit        = chk_vld_reg && (rd_data_reg.code == req_reg.dtc_code);
    assign mem_raddr  = (state_reg == S_IDLE) ? req.entry_index[IDX_W-1:0] : issue_reg;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.op == OP_REPORT)
                begin
                    state_next = S_CHECK;
                end
                else if (accept && req.op == OP_READ)
                begin
                    state_next = S_READ;
                end
            end
            S_CHECK:
            begin
                if (new_pair && cnt_reg != '0)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_DECIDE;
            S_DECIDE: state_next = S_IDLE;
            S_READ:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs: memory write, count, last pair and result
    always_comb
    begin
        logic [IDX_W-1:0] slot_idx;
        logic [IDX_W+3:0] slot_wide;
        logic [CNT_W+4:0] cnt_wide;
        slot_idx  = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '{code: req_reg.dtc_code, status: req_reg.dtc_status, tstamp: tick_reg};
        rsp_next  = '0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.op == OP_TICK)
                begin
                    done_next = 1'b1;
                end
                else if (accept && req.op == OP_CLEAR)
                begin
                    done_next = 1'b1;
                    cnt_next  = '0;
                    last_next = '0;
                end
            end
            S_CHECK:
            begin
                if (req_reg.dtc_code == 24'd0)
                begin
                    done_next       = 1'b1;
                    rsp_next.action = ACT_ZERO;
                end
                else if (!new_pair)
                begin
                    done_next       = 1'b1;
                    rsp_next.action = ACT_DUP;
                end
                else
                begin
                    last_next = pair;
                    // empty table: append straight away
                    if (cnt_reg == '0)
                    begin
                        done_next       = 1'b1;
                        mem_we          = 1'b1;
                        mem_waddr       = '0;
                        cnt_next        = CNT_W'(1);
                        rsp_next.action = ACT_APPEND;
                    end
                end
            end
            S_DECIDE:
            begin
                done_next = 1'b1;
                mem_we    = 1'b1;
                priority if (match_reg)
                begin
                    slot_idx        = match_idx_reg;
                    rsp_next.action = ACT_UPDATE;
                end
                else if (!full)
                begin
                    slot_idx        = cnt_reg[IDX_W-1:0];
                    cnt_next        = cnt_reg + CNT_W'(1);
                    rsp_next.action = ACT_APPEND;
                end
                else
                begin
                    slot_idx        = min_idx_reg;
                    rsp_next.action = ACT_REPLACE;
                end
                mem_waddr = slot_idx;
            end
            S_READ:
            begin
                done_next = 1'b1;
                if (rd_ok_reg)
                begin
                    rsp_next.entry_valid  = 1'b1;
                    rsp_next.entry_code   = rd_data_reg.code;
                    rsp_next.entry_status = rd_data_reg.status;
                    rsp_next.entry_time   = rd_data_reg.tstamp;
                end
            end
            default:
            begin
            end
        endcase
        slot_wide            = (IDX_W + 4)'(slot_idx);
        cnt_wide             = (CNT_W + 5)'(cnt_next);
        rsp_next.slot        = slot_wide[3:0];
        rsp_next.entry_count = cnt_wide[4:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            tick_reg    <= '0;
            last_reg    <= '0;
            done_reg    <= 1'b0;
            chk_vld_reg <= 1'b0;
            match_reg   <= 1'b0;
            issue_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            done_reg    <= done_next;
            chk_vld_reg <= (state_reg == S_SCAN);
            if (accept && (req.op == OP_TICK || req.op == OP_REPORT))
            begin
                tick_reg <= tick_reg + 32'd1;
            end
            // scan address
            if (accept)
            begin
                issue_reg <= '0;
            end
            else if (state_reg == S_SCAN && !issue_last)
            begin
                issue_reg <= issue_reg + IDX_W'(1);
            end
            // first matching code
            if (accept)
            begin
                match_reg <= 1'b0;
            end
            else if (hit && !match_reg)
            begin
                match_reg <= 1'b1;
            end
        end
    end

    // request capture and scan tracking
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req;
            rd_ok_reg <= ({1'b0, req.entry_index} < 9'(cnt_reg));
        end
        chk_idx_reg <= issue_reg;
        if (hit && !match_reg)
        begin
            match_idx_reg <= chk_idx_reg;
        end
        // oldest timestamp, lowest slot on a tie
        if (chk_vld_reg && (chk_idx_reg == '0 || rd_data_reg.tstamp < min_time_reg))
        begin
            min_time_reg <= rd_data_reg.tstamp;
            min_idx_reg  <= chk_idx_reg;
        end
        rsp_reg <= rsp_next;
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CHECK || state_reg == S_DECIDE))
        else $error("entry memory written outside a report");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result shown while still busy");

    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.op == OP_TICK || req.op == OP_REPORT)
        |=> tick_reg == $past(tick_reg) + 32'd1)
        else $error("tick counter did not advance by one");

    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.op == OP_REPORT |=> state_reg == S_CHECK)
        else $error("report not taken into check");

endmodule
